// File: design/hrbp_pkg.sv
`default_nettype none
package hrbp_pkg;

	localparam int unsigned LENGTH_BITS = 32;
	localparam int unsigned METHOD_MAX_CHARS = 7;
	localparam int unsigned MCHAR_BITS = 8 * METHOD_MAX_CHARS;
	localparam int unsigned MCOUNT_BITS = 4;
	localparam int unsigned CL_LEN = 14;

	typedef enum logic [4:0] {
		ST_METHOD_START = 5'd0,
		ST_METHOD       = 5'd1,
		ST_URI_START    = 5'd2,
		ST_URI          = 5'd3,
		ST_H            = 5'd4,
		ST_T1           = 5'd5,
		ST_T2           = 5'd6,
		ST_P            = 5'd7,
		ST_SLASH        = 5'd8,
		ST_MAJOR_START  = 5'd9,
		ST_MAJOR        = 5'd10,
		ST_MINOR_START  = 5'd11,
		ST_MINOR        = 5'd12,
		ST_NL1          = 5'd13,
		ST_LINE_START   = 5'd14,
		ST_LWS          = 5'd15,
		ST_NAME         = 5'd16,
		ST_SPACE        = 5'd17,
		ST_VALUE        = 5'd18,
		ST_NL2          = 5'd19,
		ST_NL3          = 5'd20,
		ST_BODY         = 5'd21,
		ST_REJECT       = 5'd22
	} pstate_t;

	localparam logic [1:0] STAT_MORE   = 2'd0;
	localparam logic [1:0] STAT_DONE   = 2'd1;
	localparam logic [1:0] STAT_REJECT = 2'd2;

	localparam logic [2:0] KIND_SYNTAX    = 3'd0;
	localparam logic [2:0] KIND_URI       = 3'd1;
	localparam logic [2:0] KIND_NAME      = 3'd2;
	localparam logic [2:0] KIND_NAME_END  = 3'd3;
	localparam logic [2:0] KIND_VALUE     = 3'd4;
	localparam logic [2:0] KIND_VALUE_END = 3'd5;
	localparam logic [2:0] KIND_BODY      = 3'd6;

	typedef struct packed {
		pstate_t                  st;
		logic [MCHAR_BITS-1:0]    mchars;
		logic [MCOUNT_BITS-1:0]   mcount;
		logic [2:0]               mheld;
		logic [7:0]               major;
		logic [7:0]               minor;
		logic                     any_hdr;
		logic [3:0]               npos;
		logic                     nmatch;
		logic                     lpres;
		logic [LENGTH_BITS-1:0]   lval;
		logic [LENGTH_BITS-1:0]   bcount;
	} pctx_t;

	typedef struct packed {
		logic [1:0]             status;
		logic [2:0]             kind;
		logic [7:0]             data;
		logic [2:0]             method;
		logic [7:0]             major;
		logic [7:0]             minor;
		logic [LENGTH_BITS-1:0] blen;
	} pres_t;

	function automatic logic is_token(input logic [7:0] c);
		logic r;
		r = (c >= 8'd33) && (c <= 8'd126);
		case (c)
			"(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"", "/", "[", "]",
			"?", "=", "{", "}": r = 1'b0;
			default: ;
		endcase
		return r;
	endfunction

	function automatic logic is_ctl(input logic [7:0] c);
		return (c < 8'd32) || (c == 8'd127);
	endfunction

	function automatic logic ascii_digit(input logic [7:0] c);
		return (c >= "0") && (c <= "9");
	endfunction

	function automatic logic [7:0] dec8(input logic [7:0] v, input logic [7:0] c);
		logic [11:0] r;
		r = {1'b0, v, 3'b000} + {3'b000, v, 1'b0} + {8'd0, c[3:0]};
		return (r > 12'd255) ? 8'd255 : r[7:0];
	endfunction

	function automatic logic [7:0] cl_char(input logic [3:0] i);
		logic [7:0] r;
		case (i)
			4'd0: r = "C";  4'd1: r = "o";  4'd2: r = "n";  4'd3: r = "t";
			4'd4: r = "e";  4'd5: r = "n";  4'd6: r = "t";  4'd7: r = "-";
			4'd8: r = "L";  4'd9: r = "e";  4'd10: r = "n"; 4'd11: r = "g";
			4'd12: r = "t"; 4'd13: r = "h";
			default: r = 8'd0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// File: design/http_request_byte_parser_unit.sv
`default_nettype none
// Channel  | Dir | Fields (tdata/tuser, lowest bit first)
// s_axis   | in  | tdata[7:0] data_byte; tuser new_request
// m_axis   | out | tdata[63:0] status, byte_kind, out_byte, method_code,
//          |     |   version_major, version_minor, body_length
//
// Each accepted byte is parsed in the cycle it is taken; its result is
// registered and appears in the cycle after. One byte per clock is
// sustained unless the output stalls; the combinational step feeds the output register.
// Reset (arst_n low) puts the parser at the start of a method token and
// empties the output register. When the output is stalled, the input
// stalls too; an empty or draining output register accepts a new byte.
module http_request_byte_parser_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,  // data_byte
	input  wire logic        s_axis_tuser,  // new_request
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [63:0]      m_axis_tdata   // status[1:0], byte_kind[4:2], out_byte[12:5],
	                                        // method_code[15:13], version_major[23:16],
	                                        // version_minor[31:24], body_length[63:32]
);
	// Parser context register; holds everything the grammar remembers.
	hrbp_pkg::pctx_t ctx_q, ctx_next, ctx_rst;
	hrbp_pkg::pres_t res_next, res_q;
	logic            take;

	assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
	assign take = s_axis_tvalid && s_axis_tready;

	hrbp_next_state u_step (
		.cur    (ctx_q),
		.c      (s_axis_tdata),
		.restart(s_axis_tuser),
		.nxt    (ctx_next),
		.res    (res_next)
	);

	always_comb begin
		ctx_rst = '0;
		ctx_rst.st = hrbp_pkg::ST_METHOD_START;
		ctx_rst.nmatch = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_q <= ctx_rst;
			m_axis_tvalid <= 1'b0;
		end else begin
			if (take) begin
				ctx_q <= ctx_next;
				m_axis_tvalid <= 1'b1;
			end else if (m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= res_next;
		end
	end

	assign m_axis_tdata = {res_q.blen, res_q.minor, res_q.major, res_q.method,
		res_q.data, res_q.kind, res_q.status};

	// A rejected byte leaves the parser in its reject state.
	a_reject_state: assert property (@(posedge clk) disable iff (!arst_n)
		take && res_next.status == hrbp_pkg::STAT_REJECT |=> ctx_q.st == hrbp_pkg::ST_REJECT)
		else $error("reject without reject state");
	// A completed request returns the parser to the method start.
	a_done_reset: assert property (@(posedge clk) disable iff (!arst_n)
		take && res_next.status == hrbp_pkg::STAT_DONE |=> ctx_q.st == hrbp_pkg::ST_METHOD_START)
		else $error("completion did not restart parser");
	// Rejected results always carry the syntax kind.
	a_reject_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && res_q.status == hrbp_pkg::STAT_REJECT |-> res_q.kind == hrbp_pkg::KIND_SYNTAX)
		else $error("reject with non-syntax kind");
endmodule
`default_nettype wire

// File: design/hrbp_method_match.sv
`default_nettype none
// Compares the collected, upper-cased method token against the eight names.
module hrbp_method_match (
	input  wire logic [hrbp_pkg::MCHAR_BITS-1:0]  mchars,
	input  wire logic [hrbp_pkg::MCOUNT_BITS-1:0] mcount,
	output logic                                  hit,
	output logic [2:0]                            code
);
	localparam int unsigned W = hrbp_pkg::MCHAR_BITS;
	localparam int unsigned CW = hrbp_pkg::MCOUNT_BITS;

	always_comb begin
		hit = 1'b1;
		code = 3'd0;
		if (mcount == CW'(3) && mchars == W'(64'h544547)) code = 3'd0;
		else if (mcount == CW'(4) && mchars == W'(64'h54534F50)) code = 3'd1;
		else if (mcount == CW'(4) && mchars == W'(64'h44414548)) code = 3'd2;
		else if (mcount == CW'(3) && mchars == W'(64'h545550)) code = 3'd3;
		else if (mcount == CW'(6) && mchars == W'(64'h4554454C4544)) code = 3'd4;
		else if (mcount == CW'(5) && mchars == W'(64'h4543415254)) code = 3'd5;
		else if (mcount == CW'(7) && mchars == W'(64'h534E4F4954504F)) code = 3'd6;
		else if (mcount == CW'(7) && mchars == W'(64'h5443454E4E4F43)) code = 3'd7;
		else hit = 1'b0;
	end
endmodule
`default_nettype wire

// File: design/hrbp_next_state.sv
`default_nettype none
// One parser step: current context and byte in, next context and result out.
module hrbp_next_state (
	input  wire hrbp_pkg::pctx_t cur,
	input  wire logic [7:0]      c,
	input  wire logic            restart,
	output hrbp_pkg::pctx_t      nxt,
	output hrbp_pkg::pres_t      res
);
	localparam int unsigned LB = hrbp_pkg::LENGTH_BITS;
	localparam int unsigned CW = hrbp_pkg::MCOUNT_BITS;
	localparam logic [LB-1:0] LMAX = '1;
	localparam logic [LB-1:0] LIM = LMAX / 10;
	localparam logic [3:0] LREM = 4'(LMAX % 10);

	hrbp_pkg::pctx_t s, rst;
	hrbp_pkg::pctx_t m_in;
	logic            hit;
	logic [2:0]      code;
	logic            bad, done;
	logic [2:0]      kind;
	logic [7:0]      uc;
	logic            cl_hdr;
	logic [LB-1:0]   bc_inc;

	hrbp_method_match u_match (
		.mchars(s.mchars),
		.mcount(s.mcount),
		.hit   (hit),
		.code  (code)
	);

	always_comb begin
		rst = '0;
		rst.st = hrbp_pkg::ST_METHOD_START;
		rst.nmatch = 1'b1;
		s = restart ? rst : cur;
		m_in = s;
		uc = (c >= "a" && c <= "z") ? c - 8'd32 : c;
		cl_hdr = s.nmatch && (s.npos == 4'(hrbp_pkg::CL_LEN));
		bc_inc = s.bcount + LB'(1);
		bad = 1'b0;
		done = 1'b0;
		kind = hrbp_pkg::KIND_SYNTAX;
		nxt = s;
		case (s.st)
			hrbp_pkg::ST_METHOD_START,
			hrbp_pkg::ST_METHOD: begin
				if (s.st == hrbp_pkg::ST_METHOD && c == " ") begin
					if (!hit) bad = 1'b1;
					else begin
						nxt.mheld = code;
						nxt.st = hrbp_pkg::ST_URI_START;
					end
				end else if (!hrbp_pkg::is_token(c)) bad = 1'b1;
				else begin
					if (s.st == hrbp_pkg::ST_METHOD_START) begin
						m_in.mchars = '0;
						m_in.mcount = '0;
					end
					nxt.st = hrbp_pkg::ST_METHOD;
					if (m_in.mcount < CW'(hrbp_pkg::METHOD_MAX_CHARS)) begin
						nxt.mchars = m_in.mchars |
							(hrbp_pkg::MCHAR_BITS'(uc) << {m_in.mcount, 3'b000});
						nxt.mcount = m_in.mcount + CW'(1);
					end else begin
						nxt.mchars = m_in.mchars;
						nxt.mcount = CW'(hrbp_pkg::METHOD_MAX_CHARS + 1);
					end
				end
			end
			hrbp_pkg::ST_URI_START: begin
				if (c >= 8'd33 && c <= 8'd126) begin
					kind = hrbp_pkg::KIND_URI;
					nxt.st = hrbp_pkg::ST_URI;
				end else bad = 1'b1;
			end
			hrbp_pkg::ST_URI: begin
				if (c == " ") nxt.st = hrbp_pkg::ST_H;
				else if (c >= 8'd33 && c <= 8'd126) kind = hrbp_pkg::KIND_URI;
				else bad = 1'b1;
			end
			hrbp_pkg::ST_H: if (c == "H") nxt.st = hrbp_pkg::ST_T1; else bad = 1'b1;
			hrbp_pkg::ST_T1: if (c == "T") nxt.st = hrbp_pkg::ST_T2; else bad = 1'b1;
			hrbp_pkg::ST_T2: if (c == "T") nxt.st = hrbp_pkg::ST_P; else bad = 1'b1;
			hrbp_pkg::ST_P: if (c == "P") nxt.st = hrbp_pkg::ST_SLASH; else bad = 1'b1;
			hrbp_pkg::ST_SLASH: begin
				if (c == "/") begin
					nxt.major = '0;
					nxt.minor = '0;
					nxt.st = hrbp_pkg::ST_MAJOR_START;
				end else bad = 1'b1;
			end
			hrbp_pkg::ST_MAJOR_START: begin
				if (hrbp_pkg::ascii_digit(c)) begin
					nxt.major = hrbp_pkg::dec8(s.major, c);
					nxt.st = hrbp_pkg::ST_MAJOR;
				end else bad = 1'b1;
			end
			hrbp_pkg::ST_MAJOR: begin
				if (c == ".") nxt.st = hrbp_pkg::ST_MINOR_START;
				else if (hrbp_pkg::ascii_digit(c)) nxt.major = hrbp_pkg::dec8(s.major, c);
				else bad = 1'b1;
			end
			hrbp_pkg::ST_MINOR_START: begin
				if (hrbp_pkg::ascii_digit(c)) begin
					nxt.minor = hrbp_pkg::dec8(s.minor, c);
					nxt.st = hrbp_pkg::ST_MINOR;
				end else bad = 1'b1;
			end
			hrbp_pkg::ST_MINOR: begin
				if (c == 8'h0D) nxt.st = hrbp_pkg::ST_NL1;
				else if (hrbp_pkg::ascii_digit(c)) nxt.minor = hrbp_pkg::dec8(s.minor, c);
				else bad = 1'b1;
			end
			hrbp_pkg::ST_NL1, hrbp_pkg::ST_NL2: begin
				if (c == 8'h0A) nxt.st = hrbp_pkg::ST_LINE_START; else bad = 1'b1;
			end
			hrbp_pkg::ST_LINE_START: begin
				if (c == 8'h0D) nxt.st = hrbp_pkg::ST_NL3;
				else if (s.any_hdr && (c == " " || c == 8'h09)) nxt.st = hrbp_pkg::ST_LWS;
				else if (!hrbp_pkg::is_token(c)) bad = 1'b1;
				else begin
					nxt.any_hdr = 1'b1;
					nxt.nmatch = (c == hrbp_pkg::cl_char(4'd0));
					nxt.npos = (c == hrbp_pkg::cl_char(4'd0)) ? 4'd1 : 4'd0;
					kind = hrbp_pkg::KIND_NAME;
					nxt.st = hrbp_pkg::ST_NAME;
				end
			end
			hrbp_pkg::ST_LWS, hrbp_pkg::ST_VALUE: begin
				if (c == 8'h0D) begin
					kind = hrbp_pkg::KIND_VALUE_END;
					nxt.st = hrbp_pkg::ST_NL2;
				end else if (s.st == hrbp_pkg::ST_LWS && (c == " " || c == 8'h09)) begin
				end else if (hrbp_pkg::is_ctl(c)) bad = 1'b1;
				else begin
					kind = hrbp_pkg::KIND_VALUE;
					nxt.st = hrbp_pkg::ST_VALUE;
					if (cl_hdr && hrbp_pkg::ascii_digit(c)) begin
						// Saturate when value*10+d would pass the all-ones limit.
						if (s.lval > LIM || (s.lval == LIM && c[3:0] > LREM))
							nxt.lval = LMAX;
						else
							nxt.lval = {s.lval[LB-4:0], 3'b000} + {s.lval[LB-2:0], 1'b0}
								+ LB'(c[3:0]);
					end
				end
			end
			hrbp_pkg::ST_NAME: begin
				if (c == ":") begin
					kind = hrbp_pkg::KIND_NAME_END;
					if (cl_hdr) begin
						nxt.lpres = 1'b1;
						nxt.lval = '0;
					end
					nxt.st = hrbp_pkg::ST_SPACE;
				end else if (!hrbp_pkg::is_token(c)) bad = 1'b1;
				else begin
					kind = hrbp_pkg::KIND_NAME;
					if (s.nmatch && s.npos < 4'(hrbp_pkg::CL_LEN) &&
						c == hrbp_pkg::cl_char(s.npos))
						nxt.npos = s.npos + 4'd1;
					else
						nxt.nmatch = 1'b0;
				end
			end
			hrbp_pkg::ST_SPACE: if (c == " ") nxt.st = hrbp_pkg::ST_VALUE; else bad = 1'b1;
			hrbp_pkg::ST_NL3: begin
				if (c != 8'h0A) bad = 1'b1;
				else if (s.lpres && s.lval != '0) begin
					nxt.bcount = '0;
					nxt.st = hrbp_pkg::ST_BODY;
				end else done = 1'b1;
			end
			hrbp_pkg::ST_BODY: begin
				kind = hrbp_pkg::KIND_BODY;
				nxt.bcount = bc_inc;
				if (bc_inc >= s.lval) done = 1'b1;
			end
			default: bad = 1'b1;
		endcase

		res.data = c;
		res.method = nxt.mheld;
		res.major = nxt.major;
		res.minor = nxt.minor;
		res.blen = nxt.lpres ? nxt.lval : '0;
		if (bad) begin
			nxt.st = hrbp_pkg::ST_REJECT;
			res.status = hrbp_pkg::STAT_REJECT;
			res.kind = hrbp_pkg::KIND_SYNTAX;
		end else begin
			res.status = done ? hrbp_pkg::STAT_DONE : hrbp_pkg::STAT_MORE;
			res.kind = kind;
		end
		if (done && !bad) nxt = rst;
	end
endmodule
`default_nettype wire
